@@ hdl/apct_pkg.sv @@
// Shared widths, request codes and record types of the rectangle pair collision table.
`default_nettype none

package apct_pkg;

    localparam int SLOTS_DEFAULT = 8;
    localparam int SLOT_FIELD_W  = 3;
    localparam int REQ_W         = 2;
    localparam int COORD_W       = 16;
    localparam int SIZE_W        = 15;
    localparam int KIND_W        = 3;
    localparam int KINDS_NZ      = 7;
    localparam int MASK_W        = KINDS_NZ * KINDS_NZ;

    localparam logic [MASK_W-1:0] PAIR_MASK_RESET = 49'd13366754732798;

    localparam logic [REQ_W-1:0] REQ_ADD      = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SWEEP    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } t_rect;

    typedef struct packed {
        t_rect             rect;
        logic [KIND_W-1:0] kind;
        logic              listener;
    } t_entry;

    typedef struct packed {
        logic hit;
        logic notify_a;
        logic notify_b;
    } t_cmp;

    typedef struct packed {
        logic [REQ_W-1:0]        req_echo;
        logic [SLOT_FIELD_W-1:0] first_slot;
        logic [SLOT_FIELD_W-1:0] second_slot;
        logic                    notify_first;
        logic                    notify_second;
        logic                    pair_valid;
        logic                    table_full;
        logic                    last_of_run;
    } t_res;

endpackage

`default_nettype wire

@@ hdl/apct_if.sv @@
// Channel interfaces of the collision table: request, result and mask write.
`default_nettype none

interface apct_req_if;
    logic                               valid;
    logic                               ready;
    logic [apct_pkg::REQ_W-1:0]         req_type;
    logic signed [apct_pkg::COORD_W-1:0] rect_x;
    logic signed [apct_pkg::COORD_W-1:0] rect_y;
    logic [apct_pkg::SIZE_W-1:0]        rect_w;
    logic [apct_pkg::SIZE_W-1:0]        rect_h;
    logic [apct_pkg::KIND_W-1:0]        collider_kind;
    logic                               has_listener;
    logic [apct_pkg::SLOT_FIELD_W-1:0]  slot;

    modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h,
                    collider_kind, has_listener, slot, input ready);
    modport sink   (input valid, req_type, rect_x, rect_y, rect_w, rect_h,
                    collider_kind, has_listener, slot, output ready);
endinterface

interface apct_res_if;
    logic                              valid;
    logic                              ready;
    logic [apct_pkg::REQ_W-1:0]        req_echo;
    logic [apct_pkg::SLOT_FIELD_W-1:0] first_slot;
    logic [apct_pkg::SLOT_FIELD_W-1:0] second_slot;
    logic                              notify_first;
    logic                              notify_second;
    logic                              pair_valid;
    logic                              table_full;
    logic                              last_of_run;

    modport source (output valid, req_echo, first_slot, second_slot, notify_first,
                    notify_second, pair_valid, table_full, last_of_run, input ready);
    modport sink   (input valid, req_echo, first_slot, second_slot, notify_first,
                    notify_second, pair_valid, table_full, last_of_run, output ready);
endinterface

interface apct_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [apct_pkg::MASK_W-1:0] pair_mask;

    modport source (output valid, pair_mask, input ready);
    modport sink   (input valid, pair_mask, output ready);
endinterface

`default_nettype wire

@@ hdl/apct_store.sv @@
// Slot memory holding rectangle, kind and listener flag, with two registered read ports.
`default_nettype none

module apct_store #(
    parameter int SLOTS = apct_pkg::SLOTS_DEFAULT,
    parameter int SLOT_W = 3
) (
    input  wire                   i_clk,
    input  wire                   i_wr_en,
    input  wire [SLOT_W-1:0]      i_wr_addr,
    input  apct_pkg::t_entry      i_wr_ent,
    input  wire                   i_rd_en,
    input  wire [SLOT_W-1:0]      i_rd_addr_a,
    input  wire [SLOT_W-1:0]      i_rd_addr_b,
    output apct_pkg::t_entry      o_rd_a,
    output apct_pkg::t_entry      o_rd_b
);

    apct_pkg::t_entry r_mem [SLOTS];
    apct_pkg::t_entry r_rd_a;
    apct_pkg::t_entry r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_ent;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

@@ hdl/apct_overlap.sv @@
// Shared pair test: strict rectangle overlap and mask lookup, result registered.
`default_nettype none

module apct_overlap (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire [apct_pkg::MASK_W-1:0]   i_mask,
    input  apct_pkg::t_entry             i_ent_a,
    input  apct_pkg::t_entry             i_ent_b,
    output apct_pkg::t_cmp               o_cmp
);

    // Kind a is told of kind b when mask bit (a-1)*7+(b-1) is set; kind none never is.
    function automatic logic told(input logic [apct_pkg::KIND_W-1:0] a,
                                  input logic [apct_pkg::KIND_W-1:0] b,
                                  input logic [apct_pkg::MASK_W-1:0] mask);
        logic [apct_pkg::KIND_W-1:0] am1;
        logic [apct_pkg::KIND_W-1:0] bm1;
        logic [5:0]                  bit_idx;
        am1     = a - 3'd1;
        bm1     = b - 3'd1;
        bit_idx = 6'(am1) * 6'(apct_pkg::KINDS_NZ) + 6'(bm1);
        return (a != '0) && (b != '0) && mask[bit_idx];
    endfunction

    logic signed [apct_pkg::COORD_W:0] ax, ay, bx, by, ar, ab, br, bb;
    apct_pkg::t_cmp n_cmp;
    apct_pkg::t_cmp r_cmp;

    always_comb begin
        ax = (apct_pkg::COORD_W+1)'(i_ent_a.rect.x);
        ay = (apct_pkg::COORD_W+1)'(i_ent_a.rect.y);
        bx = (apct_pkg::COORD_W+1)'(i_ent_b.rect.x);
        by = (apct_pkg::COORD_W+1)'(i_ent_b.rect.y);
        ar = ax + $signed({2'b00, i_ent_a.rect.w});
        ab = ay + $signed({2'b00, i_ent_a.rect.h});
        br = bx + $signed({2'b00, i_ent_b.rect.w});
        bb = by + $signed({2'b00, i_ent_b.rect.h});
        n_cmp.hit      = (br > ax) && (bx < ar) && (bb > ay) && (by < ab);
        n_cmp.notify_a = told(i_ent_a.kind, i_ent_b.kind, i_mask) && i_ent_a.listener;
        n_cmp.notify_b = told(i_ent_b.kind, i_ent_a.kind, i_mask) && i_ent_b.listener;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cmp <= n_cmp;
        end
    end

    assign o_cmp = r_cmp;

endmodule

`default_nettype wire

@@ hdl/aabb_pair_collision_table.sv @@
// Top level of the rectangle pair collision table: sequencer, slot flags and result register.
`default_nettype none

// Channel  Dir  Beat carries
// i_req    in   one request: add rectangle, remove slot or sweep all pairs
// o_res    out  one result: add or remove acknowledge, overlapping pair, sweep close
// i_cfg    in   a new value of the 49-bit pair notification mask
//
// Add and remove go from the accepted beat through the acknowledge registers to the
// result register. A sweep walks the slot pairs in order: a pair in which a slot is
// free is skipped, and a pair of valid slots passes memory read, comparator and result;
// a closing result ends the run. The single comparator and the registered read of the
// slot memory set the pace. Requests are taken only while the sequencer is idle; a full
// result register stalls it. Reset (synchronous, active low) frees every slot and
// restores the default mask; slot contents are not cleared.

module aabb_pair_collision_table #(
    parameter int SLOTS = apct_pkg::SLOTS_DEFAULT
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    apct_req_if.sink     i_req,
    apct_res_if.source   o_res,
    apct_cfg_if.sink     i_cfg
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    // Wide enough for both the three-bit slot field and the value SLOTS itself.
    localparam int EXT_W  = ((SLOT_W > apct_pkg::SLOT_FIELD_W) ? SLOT_W
                                                              : apct_pkg::SLOT_FIELD_W) + 1;
    localparam logic [SLOT_W-1:0] LAST_I = SLOT_W'(SLOTS - 2);
    localparam logic [SLOT_W-1:0] LAST_K = SLOT_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACK,
        S_PAIR,
        S_READ,
        S_EMIT,
        S_CLOSE
    } t_state;

    t_state                              r_state, n_state;
    logic [apct_pkg::MASK_W-1:0]         r_mask, n_mask;
    logic [SLOTS-1:0]                    r_slot_valid, n_slot_valid;
    logic [SLOT_W-1:0]                   r_i, n_i;
    logic [SLOT_W-1:0]                   r_k, n_k;
    logic [apct_pkg::REQ_W-1:0]          r_ack_type, n_ack_type;
    logic [apct_pkg::SLOT_FIELD_W-1:0]   r_ack_first, n_ack_first;
    logic                                r_ack_full, n_ack_full;
    logic                                r_ov, n_ov;
    apct_pkg::t_res                      r_res, n_res;

    logic                                acc;
    logic                                out_free;
    logic                                free_any;
    logic [SLOT_W-1:0]                   free_idx;
    logic [EXT_W-1:0]                    rm_ext;
    logic                                rm_in;
    logic [SLOT_W-1:0]                   rm_idx;
    logic                                adv_done;
    logic [SLOT_W-1:0]                   adv_i;
    logic [SLOT_W-1:0]                   adv_k;
    logic                                wr_en;
    logic                                rd_en;
    logic                                cmp_en;
    apct_pkg::t_entry                    wr_ent;
    apct_pkg::t_entry                    ent_a;
    apct_pkg::t_entry                    ent_b;
    apct_pkg::t_cmp                      cmp;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign acc         = i_req.valid && i_req.ready;
    // The result register can take a new result when empty or being emptied this cycle.
    assign out_free    = !r_ov || o_res.ready;

    // Lowest free slot, found by a priority search over the flags.
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int j = SLOTS - 1; j >= 0; j--) begin
            if (!r_slot_valid[j]) begin
                free_any = 1'b1;
                free_idx = SLOT_W'(j);
            end
        end
    end

    // A remove names a slot that may lie beyond the table; such a slot is left alone.
    assign rm_ext = EXT_W'(i_req.slot);
    assign rm_in  = rm_ext < EXT_W'(SLOTS);
    assign rm_idx = rm_ext[SLOT_W-1:0];

    // Next pair in the order (0,1), (0,2) ... (SLOTS-2,SLOTS-1).
    always_comb begin
        adv_done = 1'b0;
        adv_i    = r_i;
        adv_k    = r_k + SLOT_W'(1);
        if (r_k == LAST_K) begin
            if (r_i == LAST_I) begin
                adv_done = 1'b1;
            end else begin
                adv_i = r_i + SLOT_W'(1);
                adv_k = r_i + SLOT_W'(2);
            end
        end
    end

    always_comb begin
        wr_ent.rect.x   = i_req.rect_x;
        wr_ent.rect.y   = i_req.rect_y;
        wr_ent.rect.w   = i_req.rect_w;
        wr_ent.rect.h   = i_req.rect_h;
        wr_ent.kind     = i_req.collider_kind;
        wr_ent.listener = i_req.has_listener;
    end

    always_comb begin
        n_state      = r_state;
        n_mask       = r_mask;
        n_slot_valid = r_slot_valid;
        n_i          = r_i;
        n_k          = r_k;
        n_ack_type   = r_ack_type;
        n_ack_first  = r_ack_first;
        n_ack_full   = r_ack_full;
        n_ov         = r_ov && !o_res.ready;
        n_res        = r_res;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        cmp_en       = 1'b0;

        if (i_cfg.valid && i_cfg.ready) begin
            n_mask = i_cfg.pair_mask;
        end

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (i_req.req_type)
                        apct_pkg::REQ_ADD: begin
                            n_ack_type  = apct_pkg::REQ_ADD;
                            n_ack_full  = !free_any;
                            n_ack_first = free_any ? apct_pkg::SLOT_FIELD_W'(free_idx) : '0;
                            wr_en       = free_any;
                            if (free_any) begin
                                n_slot_valid[free_idx] = 1'b1;
                            end
                            n_state = S_ACK;
                        end
                        apct_pkg::REQ_REMOVE: begin
                            n_ack_type  = apct_pkg::REQ_REMOVE;
                            n_ack_full  = 1'b0;
                            n_ack_first = i_req.slot;
                            if (rm_in) begin
                                n_slot_valid[rm_idx] = 1'b0;
                            end
                            n_state = S_ACK;
                        end
                        apct_pkg::REQ_SWEEP: begin
                            n_i     = '0;
                            n_k     = SLOT_W'(1);
                            n_state = S_PAIR;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACK: begin
                if (out_free) begin
                    n_ov                = 1'b1;
                    n_res.req_echo      = r_ack_type;
                    n_res.first_slot    = r_ack_first;
                    n_res.second_slot   = '0;
                    n_res.notify_first  = 1'b0;
                    n_res.notify_second = 1'b0;
                    n_res.pair_valid    = 1'b0;
                    n_res.table_full    = r_ack_full;
                    n_res.last_of_run   = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            S_PAIR: begin
                if (r_slot_valid[r_i] && r_slot_valid[r_k]) begin
                    rd_en   = 1'b1;
                    n_state = S_READ;
                end else begin
                    n_i     = adv_i;
                    n_k     = adv_k;
                    n_state = adv_done ? S_CLOSE : S_PAIR;
                end
            end
            S_READ: begin
                cmp_en  = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (cmp.hit && (cmp.notify_a || cmp.notify_b)) begin
                    if (out_free) begin
                        n_ov                = 1'b1;
                        n_res.req_echo      = apct_pkg::REQ_SWEEP;
                        n_res.first_slot    = apct_pkg::SLOT_FIELD_W'(r_i);
                        n_res.second_slot   = apct_pkg::SLOT_FIELD_W'(r_k);
                        n_res.notify_first  = cmp.notify_a;
                        n_res.notify_second = cmp.notify_b;
                        n_res.pair_valid    = 1'b1;
                        n_res.table_full    = 1'b0;
                        n_res.last_of_run   = 1'b0;
                        n_i                 = adv_i;
                        n_k                 = adv_k;
                        n_state             = adv_done ? S_CLOSE : S_PAIR;
                    end
                end else begin
                    n_i     = adv_i;
                    n_k     = adv_k;
                    n_state = adv_done ? S_CLOSE : S_PAIR;
                end
            end
            S_CLOSE: begin
                if (out_free) begin
                    n_ov                = 1'b1;
                    n_res.req_echo      = apct_pkg::REQ_SWEEP;
                    n_res.first_slot    = '0;
                    n_res.second_slot   = '0;
                    n_res.notify_first  = 1'b0;
                    n_res.notify_second = 1'b0;
                    n_res.pair_valid    = 1'b0;
                    n_res.table_full    = 1'b0;
                    n_res.last_of_run   = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mask       <= apct_pkg::PAIR_MASK_RESET;
            r_slot_valid <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mask       <= n_mask;
            r_slot_valid <= n_slot_valid;
            r_ov         <= n_ov;
        end
        r_i         <= n_i;
        r_k         <= n_k;
        r_ack_type  <= n_ack_type;
        r_ack_first <= n_ack_first;
        r_ack_full  <= n_ack_full;
        r_res       <= n_res;
    end

    apct_store #(
        .SLOTS  (SLOTS),
        .SLOT_W (SLOT_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (free_idx),
        .i_wr_ent    (wr_ent),
        .i_rd_en     (rd_en),
        .i_rd_addr_a (r_i),
        .i_rd_addr_b (r_k),
        .o_rd_a      (ent_a),
        .o_rd_b      (ent_b)
    );

    apct_overlap u_overlap (
        .i_clk   (i_clk),
        .i_en    (cmp_en),
        .i_mask  (r_mask),
        .i_ent_a (ent_a),
        .i_ent_b (ent_b),
        .o_cmp   (cmp)
    );

    assign o_res.valid         = r_ov;
    assign o_res.req_echo      = r_res.req_echo;
    assign o_res.first_slot    = r_res.first_slot;
    assign o_res.second_slot   = r_res.second_slot;
    assign o_res.notify_first  = r_res.notify_first;
    assign o_res.notify_second = r_res.notify_second;
    assign o_res.pair_valid    = r_res.pair_valid;
    assign o_res.table_full    = r_res.table_full;
    assign o_res.last_of_run   = r_res.last_of_run;

    // A request that yields results keeps the block busy in the following cycle.
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.req_type == apct_pkg::REQ_ADD ||
                 i_req.req_type == apct_pkg::REQ_REMOVE ||
                 i_req.req_type == apct_pkg::REQ_SWEEP)) |=> !i_req.ready)
        else $error("block ready directly after a request with results");

    // The sweep walks only pairs with the lower slot first.
    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PAIR) |-> (r_i < r_k))
        else $error("sweep pair indices out of order");

    // A full table is only ever reported for an add.
    a_full_on_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.table_full) |-> (o_res.req_echo == apct_pkg::REQ_ADD))
        else $error("table full flagged on a request other than add");

    // A pair result never closes a sweep.
    a_pair_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.pair_valid && o_res.last_of_run))
        else $error("pair result marked as last of run");

endmodule

`default_nettype wire

@@ test/apct_checker.sv @@
// Scoreboard for the collision table: shadows the slot table and checks every result beat.
`default_nettype none

module apct_checker
    import apct_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    apct_req_if  i_req,
    apct_res_if  i_res,
    apct_cfg_if  i_cfg,
    output int   o_errors,
    output int   o_outstanding
);

    bit                shadow_used   [SLOTS];
    t_rect             shadow_rect   [SLOTS];
    logic [KIND_W-1:0] shadow_kind   [SLOTS];
    bit                shadow_listen [SLOTS];
    logic [MASK_W-1:0] shadow_mask = PAIR_MASK_RESET;
    t_res              due_results [$];
    int                failures = 0;
    int                owed = 0;

    assign o_errors      = failures;
    assign o_outstanding = owed;

    function automatic bit kind_told(input logic [KIND_W-1:0] a, input logic [KIND_W-1:0] b);
        if (a == 0 || b == 0)
            return 1'b0;
        return shadow_mask[(a - 1) * KINDS_NZ + (b - 1)];
    endfunction

    // Strict overlap: rectangles that only touch never overlap.
    function automatic bit rects_overlap(input t_rect p, input t_rect q);
        int px, py, pw, ph, qx, qy, qw, qh;
        px = $signed(p.x);
        py = $signed(p.y);
        pw = p.w;
        ph = p.h;
        qx = $signed(q.x);
        qy = $signed(q.y);
        qw = q.w;
        qh = q.h;
        return (qx + qw > px) && (qx < px + pw) && (qy + qh > py) && (qy < py + ph);
    endfunction

    function automatic t_res blank_result(input logic [REQ_W-1:0] op);
        t_res r;
        r             = '0;
        r.req_echo    = op;
        r.last_of_run = 1'b1;
        return r;
    endfunction

    // Applies one accepted request to the shadow table and queues the results it owes.
    function automatic void apply_request();
        t_res r;
        int   free_slot;
        int   s;
        bit   n1, n2;
        free_slot = -1;
        case (i_req.req_type)
            REQ_ADD: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!shadow_used[i])
                        free_slot = i;
                r = blank_result(REQ_ADD);
                if (free_slot < 0) begin
                    r.table_full = 1'b1;
                end else begin
                    shadow_used[free_slot]   = 1'b1;
                    shadow_rect[free_slot].x = i_req.rect_x;
                    shadow_rect[free_slot].y = i_req.rect_y;
                    shadow_rect[free_slot].w = i_req.rect_w;
                    shadow_rect[free_slot].h = i_req.rect_h;
                    shadow_kind[free_slot]   = i_req.collider_kind;
                    shadow_listen[free_slot] = i_req.has_listener;
                    r.first_slot             = free_slot[SLOT_FIELD_W-1:0];
                end
                due_results.push_back(r);
            end
            REQ_REMOVE: begin
                s = i_req.slot;
                if (s < SLOTS)
                    shadow_used[s] = 1'b0;
                r            = blank_result(REQ_REMOVE);
                r.first_slot = i_req.slot;
                due_results.push_back(r);
            end
            REQ_SWEEP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    for (int k = i + 1; k < SLOTS; k++) begin
                        if (shadow_used[i] && shadow_used[k] &&
                            rects_overlap(shadow_rect[i], shadow_rect[k])) begin
                            n1 = kind_told(shadow_kind[i], shadow_kind[k]) && shadow_listen[i];
                            n2 = kind_told(shadow_kind[k], shadow_kind[i]) && shadow_listen[k];
                            if (n1 || n2) begin
                                r               = blank_result(REQ_SWEEP);
                                r.first_slot    = i[SLOT_FIELD_W-1:0];
                                r.second_slot   = k[SLOT_FIELD_W-1:0];
                                r.notify_first  = n1;
                                r.notify_second = n2;
                                r.pair_valid    = 1'b1;
                                r.last_of_run   = 1'b0;
                                due_results.push_back(r);
                            end
                        end
                    end
                end
                due_results.push_back(blank_result(REQ_SWEEP));
            end
            default: begin
                // The reserved request code is dropped without a result.
            end
        endcase
    endfunction

    function automatic void check_result();
        t_res want, got;
        got.req_echo      = i_res.req_echo;
        got.first_slot    = i_res.first_slot;
        got.second_slot   = i_res.second_slot;
        got.notify_first  = i_res.notify_first;
        got.notify_second = i_res.notify_second;
        got.pair_valid    = i_res.pair_valid;
        got.table_full    = i_res.table_full;
        got.last_of_run   = i_res.last_of_run;
        if (due_results.size() == 0) begin
            failures++;
            if (failures <= 10)
                $display("%0t: result beat with nothing owed: req %0d slots %0d/%0d", $time,
                         got.req_echo, got.first_slot, got.second_slot);
        end else begin
            want = due_results.pop_front();
            if (got.req_echo !== want.req_echo || got.first_slot !== want.first_slot ||
                got.second_slot !== want.second_slot ||
                got.notify_first !== want.notify_first ||
                got.notify_second !== want.notify_second ||
                got.pair_valid !== want.pair_valid || got.table_full !== want.table_full ||
                got.last_of_run !== want.last_of_run) begin
                failures++;
                if (failures <= 10)
                    $display({"%0t: mismatch, expected req %0d slots %0d/%0d notify %b%b ",
                              "pair %b full %b last %b, got req %0d slots %0d/%0d notify %b%b ",
                              "pair %b full %b last %b"}, $time,
                             want.req_echo, want.first_slot, want.second_slot,
                             want.notify_first, want.notify_second, want.pair_valid,
                             want.table_full, want.last_of_run,
                             got.req_echo, got.first_slot, got.second_slot,
                             got.notify_first, got.notify_second, got.pair_valid,
                             got.table_full, got.last_of_run);
            end
        end
    endfunction

    // Results are checked before new requests are predicted: no request can produce a
    // result in the cycle it is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++)
                shadow_used[i] = 1'b0;
            shadow_mask = PAIR_MASK_RESET;
            due_results.delete();
        end else begin
            if (i_res.valid && i_res.ready)
                check_result();
            if (i_cfg.valid && i_cfg.ready)
                shadow_mask = i_cfg.pair_mask;
            if (i_req.valid && i_req.ready)
                apply_request();
        end
        owed = due_results.size();
    end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Top of the collision table testbench: clock, reset, request and mask stimulus, verdict.
`default_nettype none

module testbench;
    import apct_pkg::*;

    localparam int SLOTS = SLOTS_DEFAULT;
    // Margin for the slowest sweep, in which every pair of slots is valid, plus the closing result.
    localparam int SETTLE      = 3 * (SLOTS * (SLOTS - 1) / 2) + 2 + 8;
    localparam int IDLE_LIMIT  = 4000;
    localparam int PHASE_ITEMS = 52;
    localparam int PHASES      = 5;
    localparam int HOLD_AT     = 45;
    localparam int HOLD_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n;
    int   items_sent  = 0;
    int   idle_cycles = 0;
    bit   calm        = 1'b0;
    bit   hold_done   = 1'b0;
    int   errors;
    int   outstanding;

    apct_req_if req_ch ();
    apct_res_if res_ch ();
    apct_cfg_if cfg_ch ();

    aabb_pair_collision_table #(
        .SLOTS (SLOTS)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    apct_checker #(
        .SLOTS (SLOTS)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .i_cfg         (cfg_ch),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    always #6 clk = ~clk;

    // Idle stretch length for either side: mostly none or short, now and then long.
    // In a calm phase neither side idles at all.
    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one request beat and holds it until the block takes it. Valid stays high
    // into the next request when no gap is drawn.
    task automatic offer(input logic [REQ_W-1:0] op, input int x, input int y, input int w,
                         input int h, input int kind, input int listen, input int slot);
        int gap;
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= op;
        req_ch.rect_x        <= x[COORD_W-1:0];
        req_ch.rect_y        <= y[COORD_W-1:0];
        req_ch.rect_w        <= w[SIZE_W-1:0];
        req_ch.rect_h        <= h[SIZE_W-1:0];
        req_ch.collider_kind <= kind[KIND_W-1:0];
        req_ch.has_listener  <= listen[0];
        req_ch.slot          <= slot[SLOT_FIELD_W-1:0];
        do @(posedge clk); while (!req_ch.ready);
        if (op != REQ_RESERVED)
            items_sent++;
        gap = gap_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Brings the block to rest: every owed result in, then time for a sweep that was
    // set off by nothing visible to finish. The first edge lets the checker count the
    // request taken at the edge on which this task was entered.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] m);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.pair_mask <= m;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // Receiver. Once, early in the run, it refuses results for a long stretch while the
    // sender keeps offering, so that the result register fills and the request side
    // stalls; otherwise it stalls at random.
    initial begin
        int n;
        res_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            if (!hold_done && items_sent >= HOLD_AT) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                n = gap_len();
                if (n > 0) begin
                    res_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                res_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Watchdog: a run that stops moving beats on every channel has hung.
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL aabb_pair_collision_table");
            $finish;
        end
    end

    initial begin
        logic [MASK_W-1:0] phase_mask [PHASES];
        int                count, r, op, x, y, w, h;

        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_ADD;
        req_ch.rect_x        <= '0;
        req_ch.rect_y        <= '0;
        req_ch.rect_w        <= '0;
        req_ch.rect_h        <= '0;
        req_ch.collider_kind <= '0;
        req_ch.has_listener  <= 1'b0;
        req_ch.slot          <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.pair_mask     <= '0;

        // Mask settings of the random phases: every kind told of every kind, a random
        // mix, nobody told at all, another random mix, and back to the reset value.
        phase_mask[0] = {MASK_W{1'b1}};
        phase_mask[1] = MASK_W'({$urandom(), $urandom()});
        phase_mask[2] = '0;
        phase_mask[3] = MASK_W'({$urandom(), $urandom()});
        phase_mask[4] = PAIR_MASK_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset mask. Fill the table with all eight kinds,
        // including a rectangle covering the whole negative quarter, one that only
        // touches its corner, one with no area at the far corner, a kind none entry
        // and a wall without a listener.
        offer(REQ_ADD, -32768, -32768, 32767, 32767, 2, 1, 7);
        offer(REQ_ADD, -1, -1, 1, 1, 4, 1, 0);
        offer(REQ_ADD, 32767, 32767, 0, 0, 5, 1, 0);
        offer(REQ_ADD, -5, -5, 20, 20, 3, 1, 0);
        offer(REQ_ADD, 2, 2, 3, 3, 0, 1, 0);
        offer(REQ_ADD, -100, -100, 32767, 32767, 1, 0, 0);
        offer(REQ_ADD, 0, 0, 1, 1, 6, 1, 0);
        offer(REQ_ADD, -32768, 32767, 32767, 1, 7, 1, 0);
        // Table is full now: this add must be refused and change nothing.
        offer(REQ_ADD, 0, 0, 5, 5, 2, 1, 0);
        offer(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 0);
        // Removing a slot twice: the second remove finds it free but is still answered.
        offer(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 3);
        offer(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 3);
        offer(REQ_ADD, -3, -3, 10, 10, 5, 1, 0);
        offer(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 0);
        // The reserved code is ignored and gives no result.
        offer(REQ_RESERVED, -1, -1, 32767, 32767, 7, 1, 7);
        offer(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 7);
        offer(REQ_REMOVE, 0, 0, 0, 0, 0, 0, 0);
        offer(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 0);
        offer(REQ_ADD, 32767, -32768, 32767, 32767, 6, 1, 0);
        offer(REQ_ADD, 32766, -32768, 2, 2, 7, 1, 0);
        offer(REQ_SWEEP, 0, 0, 0, 0, 0, 0, 0);

        // Random phases. Adds outweigh removes, so the table spends much of its time
        // nearly full and sweeps find many pairs; most rectangles sit in a small
        // window so that they overlap often.
        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_mask(phase_mask[p]);
            calm  = (p == 1);
            count = 0;
            while (count < PHASE_ITEMS) begin
                r  = $urandom_range(0, 99);
                op = (r < 42) ? REQ_ADD : (r < 64) ? REQ_REMOVE :
                     (r < 96) ? REQ_SWEEP : REQ_RESERVED;
                r  = $urandom_range(0, 9);
                if (r < 8) begin
                    x = $urandom_range(0, 120);
                    x = x - 60;
                    y = $urandom_range(0, 120);
                    y = y - 60;
                    w = $urandom_range(0, 80);
                    h = $urandom_range(0, 80);
                end else if (r == 8) begin
                    x = $urandom_range(0, 65535);
                    y = $urandom_range(0, 65535);
                    w = $urandom_range(0, 32767);
                    h = $urandom_range(0, 32767);
                end else begin
                    x = ($urandom_range(0, 1) == 0) ? -32768 : 32767 - $urandom_range(0, 40);
                    y = ($urandom_range(0, 1) == 0) ? -32768 : 32767 - $urandom_range(0, 40);
                    w = 32767 - $urandom_range(0, 40);
                    h = 32767 - $urandom_range(0, 40);
                end
                offer(op[REQ_W-1:0], x, y, w, h, $urandom_range(0, 7), $urandom_range(0, 1),
                      $urandom_range(0, 7));
                if (op != REQ_RESERVED)
                    count++;
            end
        end
        calm = 1'b0;

        settle();
        if (errors == 0 && outstanding == 0)
            $display("PASS aabb_pair_collision_table");
        else
            $display("FAIL aabb_pair_collision_table");
        $finish;
    end

endmodule

`default_nettype wire

@@ aabb_pair_collision_table.f @@
hdl/apct_pkg.sv
hdl/apct_if.sv
hdl/apct_store.sv
hdl/apct_overlap.sv
hdl/aabb_pair_collision_table.sv
test/apct_checker.sv
test/testbench.sv
